// ===== hw/rtl/swm_pkg.sv =====
// Shared widths, register indexes and types of the sliding window mean unit.
`default_nettype none

package swm_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int CFG_W    = 7;
  localparam int FRAC_W   = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef struct packed {
    logic shift;
    logic head;
  } cell_ctl_t;

endpackage : swm_pkg

`default_nettype wire

// ===== hw/rtl/swm_if.sv =====
// Valid/ready channel interfaces for the sample input and the mean output.
`default_nettype none

interface swm_in_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   sample_time;
  logic [SAMPLE_W-1:0] co2_ppm;

  modport source (output valid, output sample_time, output co2_ppm, input ready);
  modport sink   (input valid, input sample_time, input co2_ppm, output ready);
endinterface : swm_in_if

interface swm_out_if
  import swm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] mean_time;
  logic [MEAN_W-1:0] mean_ppm;

  modport source (output valid, output mean_time, output mean_ppm, input ready);
  modport sink   (input valid, input mean_time, input mean_ppm, output ready);
endinterface : swm_out_if

`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
// One sample cell of the window chain: loads a new sample at the head or its neighbor's.
`default_nettype none

module swm_cell
  import swm_pkg::*;
(
  input  wire logic                clk,
  input  wire cell_ctl_t           ctl,
  input  wire logic [SAMPLE_W-1:0] din_prev,
  input  wire logic [SAMPLE_W-1:0] din_new,
  output logic      [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] sample_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample_r <= ctl.head ? din_new : din_prev;
    end
  end

  assign q = sample_r;

endmodule : swm_cell

`default_nettype wire

// ===== hw/rtl/swm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module swm_div
  import swm_pkg::*;
#(
  parameter int DVD_W = 30
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DVD_W-1:0]   dividend,
  input  wire logic [CFG_W-1:0]   divisor,
  output logic                    busy,
  output logic      [MEAN_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W-1:0] dsr_r;
  logic [CFG_W:0]   rem_sh;
  logic [CFG_W:0]   rem_diff;
  logic             fits;

  assign rem_sh   = {rem_r, dvd_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr_r};
  assign fits     = rem_sh >= {1'b0, dsr_r};
  assign busy     = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (busy) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[DVD_W-2:0], fits};
      rem_nxt = fits ? rem_diff[CFG_W-1:0] : rem_sh[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign quotient = dvd_r[MEAN_W-1:0];

endmodule : swm_div

`default_nettype wire

// ===== hw/rtl/sliding_window_mean_unit.sv =====
// Top level of the sliding window mean unit: window cell chain, running sum and divider.
// The unit averages the last N samples, where N is the window_size register saturated to
// WINDOW_MAX; a window of zero ignores samples. Samples are held in a chain of WINDOW_MAX cells
// in which each new sample enters at cell WINDOW_MAX-N and the oldest sits in the last cell.
// While the window fills, a sample gives no item; the sample that fills it and each later one
// gives one item, formed by the restoring divider as sum*256/N one quotient bit per cycle. No
// sample is taken while a division runs or its item waits for the output register, where a
// finished item waits while the next sample is taken. Writing window_size clears the window.
`default_nettype none

module sliding_window_mean_unit
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  swm_in_if.sink                 in_ch,
  swm_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int IDX_W = $clog2(WINDOW_MAX);
  localparam int SUM_W = SAMPLE_W + IDX_W;
  localparam int DVD_W = SUM_W + FRAC_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CFG_W-1:0]  window_size_r;
  logic [CFG_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [TIME_W-1:0] stamp_r;
  logic              out_valid_r;
  logic [TIME_W-1:0] mean_time_r;
  logic [MEAN_W-1:0] mean_ppm_r;

  logic [CFG_W-1:0]    n_eff;
  logic [IDX_W-1:0]    head_idx;
  logic                cfg_wr;
  logic                in_acc;
  logic                shift;
  logic                full;
  logic [CFG_W-1:0]    fill_inc;
  logic                give_result;
  logic                div_busy;
  logic [MEAN_W-1:0]   quotient;
  logic                out_free;
  logic                load_out;
  logic [SAMPLE_W-1:0] tail;
  logic [SAMPLE_W-1:0] chain [WINDOW_MAX];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_WINDOW_SIZE);

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_WINDOW_SIZE) begin
      prdata = APB_DW'(window_size_r);
    end
  end

  assign n_eff    = (int'(window_size_r) > WINDOW_MAX) ? CFG_W'(WINDOW_MAX) : window_size_r;
  assign head_idx = IDX_W'(WINDOW_MAX - int'(n_eff));

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign shift       = in_acc && (n_eff != '0);
  assign full        = (fill_r >= n_eff);
  assign fill_inc    = fill_r + 1'b1;
  assign give_result = shift && (full || (fill_inc == n_eff));
  assign tail        = chain[WINDOW_MAX-1];

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_ctl_t           ctl;
    logic [SAMPLE_W-1:0] prev;

    assign ctl.shift = shift;
    assign ctl.head  = (head_idx == IDX_W'(i));
    if (i == 0) begin : g_first
      assign prev = in_ch.co2_ppm;
    end else begin : g_rest
      assign prev = chain[i-1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .din_prev (prev),
      .din_new  (in_ch.co2_ppm),
      .q        (chain[i])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    if (cfg_wr) begin
      fill_nxt = '0;
      sum_nxt  = '0;
    end else if (shift) begin
      if (full) begin
        sum_nxt = sum_r - SUM_W'(tail) + SUM_W'(in_ch.co2_ppm);
      end else begin
        sum_nxt  = sum_r + SUM_W'(in_ch.co2_ppm);
        fill_nxt = fill_inc;
      end
    end
  end

  swm_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (give_result),
    .dividend ({sum_nxt, FRAC_W'(0)}),
    .divisor  (n_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (((state_r == S_DIV) && !div_busy) || (state_r == S_HOLD)) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (give_result) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      window_size_r <= '0;
      fill_r        <= '0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      if (cfg_wr) begin
        window_size_r <= pwdata[CFG_W-1:0];
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (give_result) begin
      stamp_r <= in_ch.sample_time;
    end
    if (load_out) begin
      mean_time_r <= stamp_r;
      mean_ppm_r  <= quotient;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.mean_time = mean_time_r;
  assign out_ch.mean_ppm  = mean_ppm_r;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= n_eff)
    else $error("fill count exceeds the effective window");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (sum_r == '0))
    else $error("empty window holds a nonzero sum");

  a_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider runs outside the divide state");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DIV || $past(state_r) == S_HOLD))
    else $error("output item appeared without a finished division");
`endif

endmodule : sliding_window_mean_unit

`default_nettype wire
